>>> design/ddee_pkg.sv
`timescale 1ns / 1ps
package ddee_pkg;
   localparam int NUM_DIGITS_DEFAULT = 10;
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;
   localparam logic [1:0] OP_SET   = 2'd3;
   localparam logic [2:0] MODE_FADE_IN  = 3'd0;
   localparam logic [2:0] MODE_FADE_OUT = 3'd1;
   localparam logic [2:0] MODE_FOG      = 3'd2;
   localparam logic [2:0] MODE_SHUFFLE  = 3'd3;
   localparam logic [2:0] MODE_BLINK    = 3'd4;
   localparam logic [2:0] REG_MODE    = 3'd0;
   localparam logic [2:0] REG_PERIOD  = 3'd1;
   localparam logic [2:0] REG_TARGET  = 3'd2;
   localparam logic [2:0] REG_SHUFFLE = 3'd3;
   localparam logic [2:0] REG_MAX     = 3'd4;
endpackage

>>> design/digit_display_effect_engine_unit.sv
`timescale 1ns / 1ps
// Digit display effect engine.
// req_ channel: one operation word per handshake (start, tick, stop, set level).
// rsp_ channel: start, stop and each tick that reaches a new step number return
//   a snapshot of NUM_DIGITS words, one per digit, tlast on the final digit.
// csr_ port: write-only register file; the user must write it only while the
//   block is idle, which the block itself does not enforce.
// Operation: a running tick with a nonzero period does a restoring divide of
//   (now - start) by the period in one shared subtract unit (one quotient bit
//   a cycle).  A new step number then walks the digits one per cycle through
//   one shared update unit (a fog step walks again for the end check and, when
//   fog ends, once more to settle the levels), and the snapshot streams out
//   one digit a cycle while rsp_tready is high.
// req_tready is low from acceptance until the last snapshot word is taken;
//   for a tick with no new step it rises when the divide ends, and a set
//   or an ignored tick keeps it high.
// A stall on rsp_tready holds the current word and keeps req_tready low.
// Reset clears all levels, the timing state and the flags; max level is 255.
module digit_display_effect_engine_unit #(
   parameter int NUM_DIGITS = ddee_pkg::NUM_DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // fields from bit 0: now_ms[31:0], random_digit[35:32], digit_index[39:36],
   // brightness_value[47:40]
   input  logic [47:0] req_tdata,
   // operation
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fields from bit 0: digit_number[3:0], level[11:4], effect_active[12], pad
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int DW = $clog2(NUM_DIGITS);
   localparam logic [DW-1:0] LAST = DW'(NUM_DIGITS - 1);
   localparam logic [4:0] NUMD = 5'(NUM_DIGITS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_CHK  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   localparam logic [2:0] MODE_FADE_IN_L = ddee_pkg::MODE_FADE_IN;
   localparam logic [2:0] MODE_FADE_OUT_L = ddee_pkg::MODE_FADE_OUT;
   localparam logic [2:0] MODE_FOG_L = ddee_pkg::MODE_FOG;
   localparam logic [2:0] MODE_SHUF_L = ddee_pkg::MODE_SHUFFLE;
   localparam logic [2:0] MODE_BLINK_L = ddee_pkg::MODE_BLINK;

   logic [2:0]  mode_ff;
   logic [15:0] period_ff, shuf_ff;
   logic [3:0]  target_ff;
   logic [7:0]  max_ff;
   logic [7:0]  lvl_ff [NUM_DIGITS];
   logic [7:0]  save_ff [NUM_DIGITS];
   logic [31:0] start_ff, count_ff, quo_ff, rem_ff;
   logic [16:0] acc_ff;
   logic        run_ff, fog_ff, blink_ff;
   logic [3:0]  lit_ff;
   logic [2:0]  st_ff;
   logic [5:0]  bit_ff;
   logic [DW-1:0] idx_ff;
   logic [1:0]  op_ff;
   logic [3:0]  rnd_ff;
   logic        fin_ff;  // finish at end of walk
   logic        allok_ff;
   logic [3:0]  rndm;
   logic [4:0]  rnd_wrap;

   logic tgt_ok;
   assign tgt_ok = {1'b0, target_ff} < NUMD;

   // random digit modulo the digit count
   always_comb begin
      rnd_wrap = {1'b0, rnd_ff};
      for (int k = 0; k < 8; k++) begin
         if (rnd_wrap >= NUMD) rnd_wrap = rnd_wrap - NUMD;
      end
   end
   assign rndm = rnd_wrap[3:0];

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tlast = (idx_ff == LAST);
   assign rsp_tdata = {3'd0, run_ff, lvl_ff[idx_ff], 4'(idx_ff)};

   // restoring divide: shift one dividend bit into the partial remainder
   logic [16:0] trial;
   logic [16:0] sh;
   assign sh = {acc_ff[15:0], rem_ff[31]};
   assign trial = sh - {1'b0, period_ff};

   // per digit update for the current walk index
   logic [7:0] cur, nxt;
   logic [3:0] cid;
   assign cur = lvl_ff[idx_ff];
   assign cid = 4'(idx_ff);
   logic done_fog_rise, done_fog_fall;
   always_comb begin
      nxt = cur;
      done_fog_rise = 1'b1;
      done_fog_fall = 1'b1;
      if (fin_ff) begin
         case (mode_ff)
            MODE_FADE_IN_L: if (cid == target_ff) nxt = max_ff;
            MODE_FADE_OUT_L: if (cid == target_ff) nxt = 8'd0;
            MODE_FOG_L, MODE_SHUF_L: nxt = (cid == target_ff) ? max_ff : 8'd0;
            MODE_BLINK_L: nxt = save_ff[idx_ff];
            default: nxt = cur;
         endcase
      end else if (st_ff == S_WALK) begin
         case (op_ff)
            ddee_pkg::OP_START: begin
               case (mode_ff)
                  MODE_FADE_IN_L: if (cid == target_ff) nxt = 8'd0;
                  MODE_SHUF_L: nxt = 8'd0;
                  default: nxt = cur;
               endcase
            end
            ddee_pkg::OP_TICK: begin
               case (mode_ff)
                  MODE_FOG_L: begin
                     if (fog_ff) begin
                        if (cur < max_ff) nxt = cur + 8'd1;
                     end else if (cid != target_ff && cur != 8'd0) begin
                        nxt = cur - 8'd1;
                     end
                  end
                  MODE_SHUF_L: begin
                     if (cid == lit_ff) nxt = 8'd0;
                     if (count_ff < {16'd0, shuf_ff} && cid == rndm) nxt = max_ff;
                  end
                  MODE_BLINK_L: nxt = blink_ff ? 8'd0 : save_ff[idx_ff];
                  default: nxt = cur;
               endcase
            end
            default: nxt = cur;
         endcase
      end
      done_fog_rise = (cur >= max_ff);
      done_fog_fall = (cid == target_ff) || (cur == 8'd0);
   end

   logic [31:0] diff;
   assign diff = req_tdata[31:0] - start_ff;
   logic [3:0] tgt_lo;
   assign tgt_lo = target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0; period_ff <= '0; target_ff <= '0; shuf_ff <= '0;
         max_ff <= 8'd255;
         for (int i = 0; i < NUM_DIGITS; i++) lvl_ff[i] <= '0;
         start_ff <= '0; count_ff <= '0; run_ff <= 1'b0; fog_ff <= 1'b0;
         blink_ff <= 1'b0; lit_ff <= '0; st_ff <= S_IDLE; idx_ff <= '0;
         fin_ff <= 1'b0; allok_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ddee_pkg::REG_MODE:    mode_ff <= csr_wdata[2:0];
               ddee_pkg::REG_PERIOD:  period_ff <= csr_wdata;
               ddee_pkg::REG_TARGET:  target_ff <= csr_wdata[3:0];
               ddee_pkg::REG_SHUFFLE: shuf_ff <= csr_wdata;
               ddee_pkg::REG_MAX:     max_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         case (st_ff)
            S_IDLE: begin
               idx_ff <= '0;
               // a stop of a running effect finishes it during the walk
               fin_ff <= req_tvalid && (req_tuser == ddee_pkg::OP_STOP) && run_ff;
               allok_ff <= 1'b1;
               if (req_tvalid) begin
                  op_ff <= req_tuser;
                  rnd_ff <= req_tdata[35:32];
                  case (req_tuser)
                     ddee_pkg::OP_START: begin
                        start_ff <= req_tdata[31:0];
                        count_ff <= '0;
                        run_ff <= 1'b1;
                        if (mode_ff == MODE_FOG_L) fog_ff <= 1'b1;
                        if (mode_ff == MODE_SHUF_L) lit_ff <= '0;
                        if (mode_ff == MODE_BLINK_L) begin
                           blink_ff <= 1'b1;
                           for (int i = 0; i < NUM_DIGITS; i++) save_ff[i] <= lvl_ff[i];
                        end
                        st_ff <= S_WALK;
                     end
                     ddee_pkg::OP_TICK: begin
                        if (run_ff && period_ff != 16'd0) begin
                           rem_ff <= diff;
                           acc_ff <= '0;
                           bit_ff <= '0;
                           st_ff <= S_DIV;
                        end
                     end
                     ddee_pkg::OP_STOP: begin
                        st_ff <= S_WALK;
                     end
                     default: begin
                        if ({1'b0, req_tdata[39:36]} < NUMD)
                           lvl_ff[req_tdata[36 +: DW]] <= (req_tdata[47:40] > max_ff) ?
                              max_ff : req_tdata[47:40];
                     end
                  endcase
               end
            end
            S_DIV: begin
               if (bit_ff == 6'd32) begin
                  // quotient complete
                  if (quo_ff == count_ff) begin
                     st_ff <= S_IDLE;
                  end else begin
                     count_ff <= quo_ff;
                     st_ff <= S_WALK;
                     case (mode_ff)
                        MODE_FADE_IN_L: if (tgt_ok) begin
                           if (lvl_ff[tgt_lo[DW-1:0]] < max_ff)
                              lvl_ff[tgt_lo[DW-1:0]] <= lvl_ff[tgt_lo[DW-1:0]] + 8'd1;
                           else fin_ff <= 1'b1;
                        end
                        MODE_FADE_OUT_L: if (tgt_ok) begin
                           if (lvl_ff[tgt_lo[DW-1:0]] != 8'd0)
                              lvl_ff[tgt_lo[DW-1:0]] <= lvl_ff[tgt_lo[DW-1:0]] - 8'd1;
                           else fin_ff <= 1'b1;
                        end
                        MODE_SHUF_L: if (quo_ff >= {16'd0, shuf_ff}) fin_ff <= 1'b1;
                        default: ;
                     endcase
                  end
               end else begin
                  // one quotient bit a cycle
                  rem_ff <= {rem_ff[30:0], 1'b0};
                  if (!trial[16]) begin
                     acc_ff <= trial;
                     quo_ff <= {quo_ff[30:0], 1'b1};
                  end else begin
                     acc_ff <= sh;
                     quo_ff <= {quo_ff[30:0], 1'b0};
                  end
                  bit_ff <= bit_ff + 6'd1;
               end
            end
            S_WALK: begin
               lvl_ff[idx_ff] <= nxt;
               if (idx_ff == LAST) begin
                  idx_ff <= '0;
                  if (fin_ff) begin
                     run_ff <= 1'b0;
                     fin_ff <= 1'b0;
                     st_ff <= S_OUT;
                  end else if (op_ff == ddee_pkg::OP_TICK) begin
                     if (mode_ff == MODE_SHUF_L) lit_ff <= rndm;
                     if (mode_ff == MODE_BLINK_L) blink_ff <= !blink_ff;
                     st_ff <= (mode_ff == MODE_FOG_L) ? S_CHK : S_OUT;
                  end else begin
                     st_ff <= S_OUT;
                  end
               end else begin
                  idx_ff <= idx_ff + DW'(1);
               end
            end
            S_CHK: begin
               // scan updated levels for the fog phase end
               if (!(fog_ff ? done_fog_rise : done_fog_fall)) allok_ff <= 1'b0;
               if (idx_ff == LAST) begin
                  idx_ff <= '0;
                  if (allok_ff && (fog_ff ? done_fog_rise : done_fog_fall)) begin
                     if (fog_ff) begin
                        fog_ff <= 1'b0;
                        st_ff <= S_OUT;
                     end else begin
                        fin_ff <= 1'b1;
                        st_ff <= S_WALK;
                     end
                  end else begin
                     st_ff <= S_OUT;
                  end
               end else begin
                  idx_ff <= idx_ff + DW'(1);
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  if (idx_ff == LAST) st_ff <= S_IDLE;
                  else idx_ff <= idx_ff + DW'(1);
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("snapshot word dropped under stall");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken during snapshot");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("no return to idle after last word");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_DIV |-> bit_ff <= 6'd32)
      else $error("divide overran");
`endif
endmodule
